### hw/rtl/chot_pkg.sv
// chot_pkg: shared types and constants of the chained hash offset table
// field widths, command and status codes, control groups between the blocks
// depends on nothing
`timescale 1ns / 1ps

package chot_pkg;

    localparam int CMD_W  = 2;
    localparam int KEY_W  = 64;
    localparam int OFF_W  = 40;
    localparam int CNT_W  = 11;
    localparam int STAT_W = 3;

    localparam logic [CNT_W-1:0] MAX_RESET = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd5;

    // strobes for the bucket head memory
    typedef struct packed {
        logic rd;
        logic wr;
    } t_head_ctl;

    // strobes for the entry store
    typedef struct packed {
        logic rd;
        logic key_wr;
        logic off_wr;
        logic link_wr;
    } t_ent_ctl;

endpackage

### hw/rtl/chot_head_store.sv
// chot_head_store: bucket head memory, one word of valid bit and entry index per bucket
// one write and one registered read per cycle
// depends on chot_pkg
`timescale 1ns / 1ps

module chot_head_store #(
    parameter int ENTRIES = 1024,
    parameter int BUCKETS = 128
) (
    input  logic                       i_clk,
    input  chot_pkg::t_head_ctl        i_ctl,
    input  logic [$clog2(BUCKETS)-1:0] i_rd_addr,
    input  logic [$clog2(BUCKETS)-1:0] i_wr_addr,
    input  logic                       i_wr_valid,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_idx,
    output logic                       o_valid,
    output logic [$clog2(ENTRIES)-1:0] o_idx
);
    import chot_pkg::*;

    localparam int EW = $clog2(ENTRIES);

    logic [EW:0] r_mem [BUCKETS];
    logic [EW:0] r_rd_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= {i_wr_valid, i_wr_idx};
        end
        if (i_ctl.rd) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    assign o_valid = r_rd_q[EW];
    assign o_idx   = r_rd_q[EW-1:0];

endmodule

### hw/rtl/chot_entry_store.sv
// chot_entry_store: entry key, offset and link memories plus the shared key comparator
// all three are read at the walk pointer; read data is registered
// depends on chot_pkg
`timescale 1ns / 1ps

module chot_entry_store #(
    parameter int ENTRIES = 1024
) (
    input  logic                       i_clk,
    input  chot_pkg::t_ent_ctl         i_ctl,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  logic [chot_pkg::KEY_W-1:0] i_key_hi,
    input  logic [chot_pkg::KEY_W-1:0] i_key_lo,
    input  logic [chot_pkg::OFF_W-1:0] i_off,
    input  logic                       i_link_valid,
    input  logic [$clog2(ENTRIES)-1:0] i_link_idx,
    output logic                       o_match,
    output logic [chot_pkg::OFF_W-1:0] o_offset,
    output logic                       o_link_valid,
    output logic [$clog2(ENTRIES)-1:0] o_link_idx
);
    import chot_pkg::*;

    localparam int EW = $clog2(ENTRIES);

    logic [2*KEY_W-1:0] r_key_mem  [ENTRIES];
    logic [OFF_W-1:0]   r_off_mem  [ENTRIES];
    logic [EW:0]        r_link_mem [ENTRIES];

    logic [2*KEY_W-1:0] r_key_q;
    logic [OFF_W-1:0]   r_off_q;
    logic [EW:0]        r_link_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.key_wr) begin
            r_key_mem[i_wr_addr] <= {i_key_hi, i_key_lo};
        end
        if (i_ctl.rd) begin
            r_key_q <= r_key_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.off_wr) begin
            r_off_mem[i_wr_addr] <= i_off;
        end
        if (i_ctl.rd) begin
            r_off_q <= r_off_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.link_wr) begin
            r_link_mem[i_wr_addr] <= {i_link_valid, i_link_idx};
        end
        if (i_ctl.rd) begin
            r_link_q <= r_link_mem[i_rd_addr];
        end
    end

    // the one comparator, reused at every node of the walk
    assign o_match      = (r_key_q == {i_key_hi, i_key_lo});
    assign o_offset     = r_off_q;
    assign o_link_valid = r_link_q[EW];
    assign o_link_idx   = r_link_q[EW-1:0];

endmodule

### hw/rtl/chot_ctrl.sv
// chot_ctrl: command sequencer, item and result registers, entry count and capacity register
// drives the head and entry stores one step per cycle unless the result output is stalled
// depends on chot_pkg
`timescale 1ns / 1ps

module chot_ctrl #(
    parameter int ENTRIES = 1024,
    parameter int BUCKETS = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [chot_pkg::CMD_W-1:0]  i_cmd,
    input  logic [chot_pkg::KEY_W-1:0]  i_key_hi,
    input  logic [chot_pkg::KEY_W-1:0]  i_key_lo,
    input  logic [chot_pkg::OFF_W-1:0]  i_offset,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [chot_pkg::STAT_W-1:0] o_status,
    output logic [chot_pkg::OFF_W-1:0]  o_offset_out,
    output logic [chot_pkg::CNT_W-1:0]  o_entry_count,
    input  logic                        i_cfg_we,
    input  logic [chot_pkg::CNT_W-1:0]  i_cfg_wdata,
    output chot_pkg::t_head_ctl         o_head_ctl,
    output logic [$clog2(BUCKETS)-1:0]  o_head_rd_addr,
    output logic [$clog2(BUCKETS)-1:0]  o_head_wr_addr,
    output logic                        o_head_wr_valid,
    output logic [$clog2(ENTRIES)-1:0]  o_head_wr_idx,
    input  logic                        i_head_valid,
    input  logic [$clog2(ENTRIES)-1:0]  i_head_idx,
    output chot_pkg::t_ent_ctl          o_ent_ctl,
    output logic [$clog2(ENTRIES)-1:0]  o_ent_rd_addr,
    output logic [$clog2(ENTRIES)-1:0]  o_ent_wr_addr,
    output logic                        o_link_wr_valid,
    output logic [$clog2(ENTRIES)-1:0]  o_link_wr_idx,
    output logic [chot_pkg::KEY_W-1:0]  o_key_hi,
    output logic [chot_pkg::KEY_W-1:0]  o_key_lo,
    output logic [chot_pkg::OFF_W-1:0]  o_off,
    input  logic                        i_match,
    input  logic [chot_pkg::OFF_W-1:0]  i_ent_offset,
    input  logic                        i_link_valid,
    input  logic [$clog2(ENTRIES)-1:0]  i_link_idx
);
    import chot_pkg::*;

    localparam int EW = $clog2(ENTRIES);
    localparam int BW = $clog2(BUCKETS);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HEAD   = 7'b0000100,
        S_NODE   = 7'b0001000,
        S_APPEND = 7'b0010000,
        S_LINK   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key_hi, n_key_hi;
    logic [KEY_W-1:0]  r_key_lo, n_key_lo;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [BW-1:0]     r_bucket, n_bucket;
    logic [BW-1:0]     r_sweep, n_sweep;
    logic [EW-1:0]     r_ptr, n_ptr;
    logic              r_has_tail, n_has_tail;
    logic [CW-1:0]     r_used, n_used;
    logic [CNT_W-1:0]  r_max, n_max;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [OFF_W-1:0]  r_res_off, n_res_off;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [OFF_W-1:0]  r_offset_out, n_offset_out;
    logic [CNT_W-1:0]  r_count, n_count;

    logic [BW-1:0] w_bucket_in;
    logic [EW-1:0] w_new_idx;
    logic          w_full;
    logic          w_out_free;

    // bucket is bits 63:32 of the low key word masked to the bucket count
    assign w_bucket_in = BW'(i_key_lo[63:32] & 32'(BUCKETS - 1));
    assign w_new_idx   = r_used[EW-1:0];
    assign w_full      = (32'(r_used) >= 32'(r_max)) || (32'(r_used) >= 32'(ENTRIES));
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key_hi     = r_key_hi;
        n_key_lo     = r_key_lo;
        n_off        = r_off;
        n_bucket     = r_bucket;
        n_sweep      = r_sweep;
        n_ptr        = r_ptr;
        n_has_tail   = r_has_tail;
        n_used       = r_used;
        n_max        = i_cfg_we ? i_cfg_wdata : r_max;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_offset_out = r_offset_out;
        n_count      = r_count;

        o_head_ctl      = '0;
        o_head_rd_addr  = w_bucket_in;
        o_head_wr_addr  = r_bucket;
        o_head_wr_valid = 1'b0;
        o_head_wr_idx   = w_new_idx;
        o_ent_ctl       = '0;
        o_ent_rd_addr   = i_link_idx;
        o_ent_wr_addr   = r_ptr;
        o_link_wr_valid = 1'b0;
        o_link_wr_idx   = '0;

        case (r_state)
            S_CLEAR: begin
                o_head_ctl.wr  = 1'b1;
                o_head_wr_addr = r_sweep;
                n_sweep        = r_sweep + BW'(1);
                if (r_sweep == BW'(BUCKETS - 1)) begin
                    n_sweep = '0;
                    // the pass after reset gives no result
                    if (r_cmd == CMD_CLEAR) begin
                        n_res_status = ST_CLEARED;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd        = i_cmd;
                    n_key_hi     = i_key_hi;
                    n_key_lo     = i_key_lo;
                    n_off        = i_offset;
                    n_bucket     = w_bucket_in;
                    n_res_off    = '0;
                    n_res_status = ST_MISS;
                    o_head_ctl.rd = 1'b1;
                    case (i_cmd)
                        CMD_FIND: begin
                            n_state = S_HEAD;
                        end
                        CMD_ADD: begin
                            if (w_full) begin
                                n_res_status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_HEAD;
                            end
                        end
                        CMD_CLEAR: begin
                            n_used  = '0;
                            n_sweep = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                n_has_tail = 1'b0;
                if (i_head_valid) begin
                    o_ent_ctl.rd  = 1'b1;
                    o_ent_rd_addr = i_head_idx;
                    n_ptr         = i_head_idx;
                    n_state       = S_NODE;
                end else if (r_cmd == CMD_ADD) begin
                    n_state = S_APPEND;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_NODE: begin
                if (i_match) begin
                    if (r_cmd == CMD_ADD) begin
                        o_ent_ctl.off_wr = 1'b1;
                        n_res_status     = ST_UPDATED;
                    end else begin
                        n_res_status = ST_HIT;
                        n_res_off    = i_ent_offset;
                    end
                    n_state = S_DONE;
                end else if (i_link_valid) begin
                    o_ent_ctl.rd = 1'b1;
                    n_ptr        = i_link_idx;
                end else begin
                    // r_ptr now holds the chain tail
                    n_has_tail = 1'b1;
                    n_state    = (r_cmd == CMD_ADD) ? S_APPEND : S_DONE;
                end
            end
            S_APPEND: begin
                o_ent_ctl.key_wr  = 1'b1;
                o_ent_ctl.off_wr  = 1'b1;
                o_ent_ctl.link_wr = 1'b1;
                o_ent_wr_addr     = w_new_idx;
                n_res_status      = ST_INSERTED;
                if (r_has_tail) begin
                    n_state = S_LINK;
                end else begin
                    o_head_ctl.wr   = 1'b1;
                    o_head_wr_valid = 1'b1;
                    n_used          = r_used + CW'(1);
                    n_state         = S_DONE;
                end
            end
            S_LINK: begin
                o_ent_ctl.link_wr = 1'b1;
                o_link_wr_valid   = 1'b1;
                o_link_wr_idx     = w_new_idx;
                n_used            = r_used + CW'(1);
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_status     = r_res_status;
                    n_offset_out = r_res_off;
                    n_count      = CNT_W'(r_used);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cmd       <= CMD_FIND;
            r_sweep     <= '0;
            r_has_tail  <= 1'b0;
            r_used      <= '0;
            r_max       <= MAX_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_sweep     <= n_sweep;
            r_has_tail  <= n_has_tail;
            r_used      <= n_used;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_hi     <= n_key_hi;
        r_key_lo     <= n_key_lo;
        r_off        <= n_off;
        r_bucket     <= n_bucket;
        r_ptr        <= n_ptr;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_status     <= n_status;
        r_offset_out <= n_offset_out;
        r_count      <= n_count;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_offset_out  = r_offset_out;
    assign o_entry_count = r_count;
    assign o_key_hi      = r_key_hi;
    assign o_key_lo      = r_key_lo;
    assign o_off         = r_off;

endmodule

### hw/rtl/chained_hash_offset_table.sv
// chained_hash_offset_table: top level of the digest-to-offset hash table
// instantiates chot_ctrl, chot_head_store and chot_entry_store; depends on chot_pkg
//
//   channel   direction  handshake                  beat
//   in        to block   i_in_valid / o_in_stall    i_cmd, i_key_hi, i_key_lo, i_offset
//   out       from block o_out_valid / i_out_stall  o_status, o_offset_out, o_entry_count
//   cfg       to block   i_cfg_we                   i_cfg_wdata (max_entries)
//
// one beat is worked on at a time; the walk reads one chain entry per cycle through the comparator
// a find walks the chain to a match or its end, an update stops at the match, an insert writes
// the new entry and the bucket head, or then the tail link, a rejected add or unused command goes
// straight to the result and a clear sweeps every bucket head; the result shows in the same
// cycle as the next beat can be taken; after reset the head memory is swept before the first beat
// a finished result waits in the output register and the next beat is taken meanwhile
`timescale 1ns / 1ps

module chained_hash_offset_table #(
    parameter int ENTRIES = 1024,
    parameter int BUCKETS = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [chot_pkg::CMD_W-1:0]  i_cmd,
    input  logic [chot_pkg::KEY_W-1:0]  i_key_hi,
    input  logic [chot_pkg::KEY_W-1:0]  i_key_lo,
    input  logic [chot_pkg::OFF_W-1:0]  i_offset,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [chot_pkg::STAT_W-1:0] o_status,
    output logic [chot_pkg::OFF_W-1:0]  o_offset_out,
    output logic [chot_pkg::CNT_W-1:0]  o_entry_count,
    input  logic                        i_cfg_we,
    input  logic [chot_pkg::CNT_W-1:0]  i_cfg_wdata
);
    import chot_pkg::*;

    localparam int EW = $clog2(ENTRIES);
    localparam int BW = $clog2(BUCKETS);

    t_head_ctl        w_head_ctl;
    logic [BW-1:0]    w_head_rd_addr;
    logic [BW-1:0]    w_head_wr_addr;
    logic             w_head_wr_valid;
    logic [EW-1:0]    w_head_wr_idx;
    logic             w_head_valid;
    logic [EW-1:0]    w_head_idx;
    t_ent_ctl         w_ent_ctl;
    logic [EW-1:0]    w_ent_rd_addr;
    logic [EW-1:0]    w_ent_wr_addr;
    logic             w_link_wr_valid;
    logic [EW-1:0]    w_link_wr_idx;
    logic [KEY_W-1:0] w_key_hi;
    logic [KEY_W-1:0] w_key_lo;
    logic [OFF_W-1:0] w_off;
    logic             w_match;
    logic [OFF_W-1:0] w_ent_offset;
    logic             w_link_valid;
    logic [EW-1:0]    w_link_idx;

    chot_ctrl #(
        .ENTRIES (ENTRIES),
        .BUCKETS (BUCKETS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_key_hi        (i_key_hi),
        .i_key_lo        (i_key_lo),
        .i_offset        (i_offset),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_offset_out    (o_offset_out),
        .o_entry_count   (o_entry_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_head_ctl      (w_head_ctl),
        .o_head_rd_addr  (w_head_rd_addr),
        .o_head_wr_addr  (w_head_wr_addr),
        .o_head_wr_valid (w_head_wr_valid),
        .o_head_wr_idx   (w_head_wr_idx),
        .i_head_valid    (w_head_valid),
        .i_head_idx      (w_head_idx),
        .o_ent_ctl       (w_ent_ctl),
        .o_ent_rd_addr   (w_ent_rd_addr),
        .o_ent_wr_addr   (w_ent_wr_addr),
        .o_link_wr_valid (w_link_wr_valid),
        .o_link_wr_idx   (w_link_wr_idx),
        .o_key_hi        (w_key_hi),
        .o_key_lo        (w_key_lo),
        .o_off           (w_off),
        .i_match         (w_match),
        .i_ent_offset    (w_ent_offset),
        .i_link_valid    (w_link_valid),
        .i_link_idx      (w_link_idx)
    );

    chot_head_store #(
        .ENTRIES (ENTRIES),
        .BUCKETS (BUCKETS)
    ) u_head (
        .i_clk      (i_clk),
        .i_ctl      (w_head_ctl),
        .i_rd_addr  (w_head_rd_addr),
        .i_wr_addr  (w_head_wr_addr),
        .i_wr_valid (w_head_wr_valid),
        .i_wr_idx   (w_head_wr_idx),
        .o_valid    (w_head_valid),
        .o_idx      (w_head_idx)
    );

    chot_entry_store #(
        .ENTRIES (ENTRIES)
    ) u_entry (
        .i_clk        (i_clk),
        .i_ctl        (w_ent_ctl),
        .i_rd_addr    (w_ent_rd_addr),
        .i_wr_addr    (w_ent_wr_addr),
        .i_key_hi     (w_key_hi),
        .i_key_lo     (w_key_lo),
        .i_off        (w_off),
        .i_link_valid (w_link_wr_valid),
        .i_link_idx   (w_link_wr_idx),
        .o_match      (w_match),
        .o_offset     (w_ent_offset),
        .o_link_valid (w_link_valid),
        .o_link_idx   (w_link_idx)
    );

endmodule

### hw/rtl/chot_checker.sv
// chot_checker: port-level assertions for chained_hash_offset_table
// bound to the top level below; depends on chot_pkg
`timescale 1ns / 1ps

module chot_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [chot_pkg::STAT_W-1:0] o_status,
    input logic [chot_pkg::OFF_W-1:0]  o_offset_out,
    input logic [chot_pkg::CNT_W-1:0]  o_entry_count
);
    import chot_pkg::*;

    // a held result beat does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_offset_out)
            && $stable(o_entry_count))
        else $error("result beat changed while stalled");

    // one beat at a time: after taking a beat the block stalls its input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a beat is in work");

    // only a find hit carries an offset
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_HIT) |-> (o_offset_out == '0))
        else $error("offset on a result other than a hit");

    // a clear leaves the table empty
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_CLEARED) |-> (o_entry_count == '0))
        else $error("entry count not zero after clear");

endmodule

bind chained_hash_offset_table chot_checker u_chot_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_offset_out  (o_offset_out),
    .o_entry_count (o_entry_count)
);

### tb/tb_top.sv
// tb_top: self-checking testbench for chained_hash_offset_table
// keeps its own copy of the buckets and slots and checks every result beat against it
// depends on chot_pkg and chained_hash_offset_table
`timescale 1ns / 1ps

module tb_top;
    import chot_pkg::*;

    localparam int ENTRIES = 1024;
    localparam int BUCKETS = 128;
    localparam int HASH_W  = $clog2(BUCKETS);
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic [CNT_W-1:0] CAP_TOP   = 11'h7FF;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [KEY_W-1:0] hi;
        logic [KEY_W-1:0] lo;
    } t_digest;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  offset;
        logic [CNT_W-1:0]  count;
    } t_table_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [CMD_W-1:0]   i_cmd = CMD_FIND;
    logic [KEY_W-1:0]   i_key_hi = '0;
    logic [KEY_W-1:0]   i_key_lo = '0;
    logic [OFF_W-1:0]   i_offset = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [OFF_W-1:0]   o_offset_out;
    logic [CNT_W-1:0]   o_entry_count;
    logic               i_cfg_we = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata = '0;

    // shadow of the table
    logic [KEY_W-1:0]   slot_khi [ENTRIES];
    logic [KEY_W-1:0]   slot_klo [ENTRIES];
    logic [OFF_W-1:0]   slot_off [ENTRIES];
    int unsigned        slot_next [ENTRIES];
    logic               slot_next_ok [ENTRIES];
    int unsigned        bucket_first [BUCKETS];
    logic               bucket_first_ok [BUCKETS];
    int unsigned        slots_used = 0;
    logic [CNT_W-1:0]   cap_limit = MAX_RESET;

    t_table_answer      answers_due [$];
    t_table_answer      due;
    t_digest            known_keys [$];
    int unsigned        n_faults = 0;
    bit                 quiet_run = 1'b0;
    int unsigned        hold_asks = 0;
    int unsigned        holds_served = 0;
    int unsigned        hold_left = 0;

    chained_hash_offset_table #(
        .ENTRIES(ENTRIES),
        .BUCKETS(BUCKETS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_key_hi     (i_key_hi),
        .i_key_lo     (i_key_lo),
        .i_offset     (i_offset),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_offset_out (o_offset_out),
        .o_entry_count(o_entry_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // answer of the table to one command, updating the shadow copy
    function automatic t_table_answer table_apply(input logic [CMD_W-1:0] cmd,
                                                  input t_digest k,
                                                  input logic [OFF_W-1:0] off);
        t_table_answer ans;
        int unsigned b, idx, tail, hit, steps, n;
        logic live, has_tail, found;
        ans.status = ST_MISS;
        ans.offset = '0;
        b = 32'(k.lo[32 +: HASH_W]);
        live = bucket_first_ok[b];
        idx = bucket_first[b];
        steps = 0;
        tail = 0;
        hit = 0;
        has_tail = 1'b0;
        found = 1'b0;
        if (cmd == CMD_FIND || cmd == CMD_ADD) begin
            while (live && idx < ENTRIES && steps < ENTRIES && !found) begin
                tail = idx;
                has_tail = 1'b1;
                if (slot_khi[idx] == k.hi && slot_klo[idx] == k.lo) begin
                    found = 1'b1;
                    hit = idx;
                end else begin
                    live = slot_next_ok[idx];
                    idx = slot_next[idx];
                    steps++;
                end
            end
        end
        case (cmd)
            CMD_FIND: begin
                if (found) begin
                    ans.status = ST_HIT;
                    ans.offset = slot_off[hit];
                end
            end
            CMD_ADD: begin
                // capacity is checked before the walk, so a known key is refused too
                if (slots_used >= 32'(cap_limit) || slots_used >= ENTRIES) begin
                    ans.status = ST_FULL;
                end else if (found) begin
                    slot_off[hit] = off;
                    ans.status = ST_UPDATED;
                end else begin
                    n = slots_used;
                    slot_khi[n] = k.hi;
                    slot_klo[n] = k.lo;
                    slot_off[n] = off;
                    slot_next[n] = 0;
                    slot_next_ok[n] = 1'b0;
                    if (has_tail) begin
                        slot_next[tail] = n;
                        slot_next_ok[tail] = 1'b1;
                    end else begin
                        bucket_first[b] = n;
                        bucket_first_ok[b] = 1'b1;
                    end
                    slots_used = n + 1;
                    ans.status = ST_INSERTED;
                end
            end
            CMD_CLEAR: begin
                foreach (bucket_first_ok[i]) bucket_first_ok[i] = 1'b0;
                slots_used = 0;
                ans.status = ST_CLEARED;
            end
            default: ;
        endcase
        ans.count = slots_used[CNT_W-1:0];
        return ans;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [OFF_W-1:0] rand_off();
        logic [63:0] r;
        r = rand64();
        return r[OFF_W-1:0];
    endfunction

    function automatic t_digest fresh_digest(input int unsigned b);
        t_digest k;
        k.hi = rand64();
        k.lo = rand64();
        k.lo[32 +: HASH_W] = b[HASH_W-1:0];
        return k;
    endfunction

    function automatic t_digest any_known();
        return known_keys[$urandom_range(known_keys.size() - 1)];
    endfunction

    function automatic void remember_key(input t_digest k);
        known_keys.insert(known_keys.size(), k);
        if (known_keys.size() > 300)
            known_keys.delete($urandom_range(known_keys.size() - 1));
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        n_faults++;
        $display("tb_top: mismatch in %s, got %0h, want %0h at %0t ns",
                 what, got, want, $time);
    endtask

    // one beat on the input channel; the answer is worked out at the accepting edge
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input t_digest k,
                             input logic [OFF_W-1:0] off);
        while (!quiet_run && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_key_hi <= k.hi;
        i_key_lo <= k.lo;
        i_offset <= off;
        do @(posedge i_clk); while (o_in_stall);
        answers_due.insert(answers_due.size(), table_apply(cmd, k, off));
    endtask

    task automatic wait_all_answered();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CNT_W-1:0] value);
        wait_all_answered();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        cap_limit = value;
        i_cfg_we <= 1'b0;
    endtask

    // result side: check each beat and drive the stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_due.size() == 0) begin
                flag_mismatch("result beat with nothing due", 64'(o_status), 64'(0));
            end else begin
                due = answers_due[0];
                answers_due.delete(0);
                if (o_status !== due.status)
                    flag_mismatch("status", 64'(o_status), 64'(due.status));
                if (o_offset_out !== due.offset)
                    flag_mismatch("offset_out", 64'(o_offset_out), 64'(due.offset));
                if (o_entry_count !== due.count)
                    flag_mismatch("entry_count", 64'(o_entry_count), 64'(due.count));
            end
        end
        if (hold_asks != holds_served) begin
            holds_served = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet_run && ($urandom_range(99) < 23);
        end
    end

    task automatic test_basic_ops();
        t_digest ka, kb, kc, ke, near;
        ka.hi = '1;
        ka.lo = '0;
        kb.hi = '0;
        kb.lo = '0;
        kc.hi = rand64();
        kc.lo = '1;
        // upper key bits above the bucket field set, still bucket zero
        ke.hi = 64'h8000_0000_0000_0001;
        ke.lo = 64'hFFFF_FF80_FFFF_FFFF;
        near = ka;
        near.lo[0] = 1'b1;
        send_beat(CMD_FIND, ka, rand_off());
        send_beat(CMD_SPARE, '1, '1);
        send_beat(CMD_ADD, ka, '1);
        send_beat(CMD_ADD, kb, '0);
        send_beat(CMD_ADD, ke, rand_off());
        send_beat(CMD_ADD, kc, rand_off());
        send_beat(CMD_FIND, kb, '1);
        send_beat(CMD_FIND, ke, '0);
        send_beat(CMD_FIND, ka, rand_off());
        send_beat(CMD_FIND, kc, rand_off());
        send_beat(CMD_ADD, kb, 40'h12_3456_789A);
        send_beat(CMD_FIND, kb, rand_off());
        send_beat(CMD_FIND, near, rand_off());
        send_beat(CMD_CLEAR, fresh_digest($urandom), rand_off());
        send_beat(CMD_FIND, ka, rand_off());
        // first slot is handed out again after the clear
        send_beat(CMD_ADD, kc, rand_off());
        send_beat(CMD_FIND, kc, rand_off());
        send_beat(CMD_FIND, kb, rand_off());
        send_beat(CMD_CLEAR, '0, '0);
        send_beat(CMD_SPARE, '0, '0);
    endtask

    task automatic test_capacity_limit();
        t_digest k [4];
        foreach (k[i]) k[i] = fresh_digest($urandom_range(0, 3));
        set_capacity('0);
        send_beat(CMD_ADD, k[0], rand_off());
        send_beat(CMD_FIND, k[0], rand_off());
        set_capacity(11'd3);
        for (int i = 0; i < 4; i++) send_beat(CMD_ADD, k[i], rand_off());
        send_beat(CMD_ADD, k[0], rand_off());
        send_beat(CMD_FIND, k[0], rand_off());
        send_beat(CMD_FIND, k[3], rand_off());
        send_beat(CMD_CLEAR, k[1], rand_off());
        send_beat(CMD_ADD, k[3], rand_off());
        send_beat(CMD_FIND, k[3], rand_off());
        send_beat(CMD_CLEAR, k[2], rand_off());
        set_capacity(MAX_RESET);
    endtask

    task automatic test_long_chain();
        t_digest chain [80];
        t_digest absent;
        int unsigned b;
        b = $urandom_range(BUCKETS - 1);
        foreach (chain[i]) begin
            chain[i] = fresh_digest(b);
            send_beat(CMD_ADD, chain[i], rand_off());
        end
        send_beat(CMD_FIND, chain[0], rand_off());
        send_beat(CMD_FIND, chain[40], rand_off());
        send_beat(CMD_FIND, chain[79], rand_off());
        send_beat(CMD_ADD, chain[79], rand_off());
        send_beat(CMD_FIND, chain[79], rand_off());
        absent = fresh_digest(b);
        send_beat(CMD_FIND, absent, rand_off());
        send_beat(CMD_CLEAR, absent, rand_off());
    endtask

    // output held off long enough for the block to stall its input
    task automatic test_backpressure();
        t_digest k;
        hold_asks++;
        for (int i = 0; i < 12; i++) begin
            k = fresh_digest($urandom_range(0, 7));
            remember_key(k);
            send_beat((i % 3 == 2) ? CMD_FIND : CMD_ADD, k, rand_off());
        end
        wait_all_answered();
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        t_digest k;
        int unsigned r;
        quiet_run = 1'b1;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i == 150) quiet_run = 1'b0;
            if (i == 400) set_capacity(11'($urandom_range(20, 120)));
            if (i == 600) set_capacity(CAP_TOP);
            r = $urandom_range(99);
            if (known_keys.size() != 0 && $urandom_range(9) < 6) k = any_known();
            else if ($urandom_range(9) < 7) k = fresh_digest($urandom_range(0, 15));
            else k = fresh_digest($urandom);
            if (r < 40) begin
                send_beat(CMD_FIND, k, rand_off());
            end else if (r < 86) begin
                remember_key(k);
                send_beat(CMD_ADD, k, rand_off());
            end else if (r < 89) begin
                send_beat(CMD_CLEAR, k, rand_off());
            end else if (r < 92) begin
                send_beat(CMD_SPARE, k, rand_off());
            end else begin
                // same bucket, one key bit off
                k.hi[$urandom_range(KEY_W - 1)] ^= 1'b1;
                send_beat(CMD_FIND, k, rand_off());
            end
        end
        wait_all_answered();
    endtask

    initial begin
        foreach (bucket_first_ok[i]) bucket_first_ok[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_capacity_limit();
        test_long_chain();
        test_backpressure();
        test_random_traffic(620);
        wait_all_answered();
        repeat (50) @(posedge i_clk);
        if (n_faults == 0 && answers_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### chained_hash_offset_table.f
hw/rtl/chot_pkg.sv
hw/rtl/chot_head_store.sv
hw/rtl/chot_entry_store.sv
hw/rtl/chot_ctrl.sv
hw/rtl/chained_hash_offset_table.sv
hw/rtl/chot_checker.sv
tb/tb_top.sv
